// ===== hw/rtl/erm_pkg.sv =====
// ----------------------------------------------------------------------------
// erm_pkg: shared types, constants and arithmetic for the Euler rotation core
// Holds the stream payload types, the Q2.14 helpers and the sine table builder.
// ----------------------------------------------------------------------------
package erm_pkg;

    localparam int ANGLE_W             = 16;  // input angle field width
    localparam int COEF_W              = 16;  // signed Q2.14 coefficient width
    localparam int SINE_VAL_W          = 15;  // unsigned table entry, up to 1.0
    localparam int AXES                = 3;
    localparam int SINE_TABLE_BITS_DEF = 8;
    localparam int ANGLE_BITS_DEF      = 16;
    localparam int SINE_BITS_MAX       = 12;
    localparam int SINE_IDX_W          = SINE_BITS_MAX + 1;
    localparam int QUEUE_DEPTH_DEF     = 4;

    localparam logic signed [COEF_W-1:0] ONE_Q14     = 16'sd16384;
    localparam logic signed [COEF_W:0]   ONE_Q14_EXT = 17'sd16384;
    localparam logic [63:0]              HALF_PI_Q30 = 64'd1686629713;

    // Taylor series divisors (2n)(2n+1) for n = 1..8
    localparam int unsigned TAYLOR_DIV [8] = '{6, 20, 42, 72, 110, 156, 210, 272};

    typedef struct packed {
        logic [ANGLE_W-1:0] angle_x;
        logic [ANGLE_W-1:0] angle_y;
        logic [ANGLE_W-1:0] angle_z;
    } t_angles;

    typedef struct packed {
        logic signed [COEF_W-1:0] m00;
        logic signed [COEF_W-1:0] m01;
        logic signed [COEF_W-1:0] m02;
        logic signed [COEF_W-1:0] m10;
        logic signed [COEF_W-1:0] m11;
        logic signed [COEF_W-1:0] m12;
        logic signed [COEF_W-1:0] m20;
        logic signed [COEF_W-1:0] m21;
        logic signed [COEF_W-1:0] m22;
    } t_matrix;

    // One table read: quarter-wave index and sign of the result
    typedef struct packed {
        logic [SINE_IDX_W-1:0] idx;
        logic                  neg;
    } t_trig;

    // Classified word between front and back; index 0 is x, 1 is y, 2 is z
    typedef struct packed {
        t_trig [AXES-1:0] sin_t;
        t_trig [AXES-1:0] cos_t;
    } t_lookup_req;

    // Quarter-wave sine entry k, evaluated at elaboration time only
    function automatic logic [SINE_VAL_W-1:0] sine_entry(input int unsigned k,
                                                         input int unsigned tb);
        logic [63:0] kk;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] rnd;
        longint      sum;
        kk = 64'(k);
        if (kk > (64'd1 << tb)) begin
            kk = 64'd1 << tb;
        end
        x    = (kk * HALF_PI_Q30) >> tb;
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(term);
        for (int n = 1; n <= 8; n++) begin
            term = (term * x2) >> 30;
            term = term / 64'(TAYLOR_DIV[n-1]);
            if ((n & 1) == 1) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        rnd = (64'(sum) * 64'd16384 + (64'd1 << 29)) >> 30;
        return rnd[SINE_VAL_W-1:0];
    endfunction

    // Q2.14 product, rounded half up
    function automatic logic signed [COEF_W-1:0] mul_q14(input logic signed [COEF_W-1:0] a,
                                                         input logic signed [COEF_W-1:0] b);
        logic signed [2*COEF_W-1:0] p;
        p = a * b + 32'sd8192;
        return p[29:14];
    endfunction

    // Clamp a widened sum to plus or minus one
    function automatic logic signed [COEF_W-1:0] sat_q14(input logic signed [COEF_W:0] s);
        logic signed [COEF_W-1:0] r;
        if (s > ONE_Q14_EXT) begin
            r = ONE_Q14;
        end else if (s < -ONE_Q14_EXT) begin
            r = -ONE_Q14;
        end else begin
            r = s[COEF_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/erm_stream_if.sv =====
// ----------------------------------------------------------------------------
// erm_stream_if: valid/ready stream channel
// Carries one payload word of type T per handshake.
// ----------------------------------------------------------------------------
interface erm_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/erm_front.sv =====
// ----------------------------------------------------------------------------
// erm_front: angle intake and quadrant classification
// Maps each angle to a table phase, rounding it when wider, and turns it into sine and cosine reads.
// ----------------------------------------------------------------------------
module erm_front #(
    parameter int SINE_TABLE_BITS = erm_pkg::SINE_TABLE_BITS_DEF,
    parameter int ANGLE_BITS      = erm_pkg::ANGLE_BITS_DEF
) (
    erm_stream_if.sink   i_angle,
    erm_stream_if.source o_req
);
    import erm_pkg::*;

    localparam int STB = SINE_TABLE_BITS;
    localparam int AB  = ANGLE_BITS;
    localparam int PW  = STB + 2;
    localparam int UP  = PW - AB;
    localparam int SH  = (UP < 0) ? -UP : 1;

    logic [ANGLE_W-1:0] w_raw [AXES];
    t_trig              w_sin [AXES];
    t_trig              w_cos [AXES];

    function automatic t_trig classify(input logic [1:0] quad, input logic [STB-1:0] r);
        logic [STB:0] idx;
        t_trig        t;
        // odd quadrants read the table mirrored
        idx   = quad[0] ? (((STB+1)'(1) << STB) - {1'b0, r}) : {1'b0, r};
        t.idx = SINE_IDX_W'(idx);
        t.neg = quad[1];
        return t;
    endfunction

    assign w_raw[0] = i_angle.data.angle_x;
    assign w_raw[1] = i_angle.data.angle_y;
    assign w_raw[2] = i_angle.data.angle_z;

    for (genvar g = 0; g < AXES; g++) begin : g_axis
        logic [AB-1:0] w_masked;
        logic [PW-1:0] w_phase;

        if (AB <= ANGLE_W) begin : g_trunc
            assign w_masked = w_raw[g][AB-1:0];
        end else begin : g_ext
            assign w_masked = {{(AB-ANGLE_W){1'b0}}, w_raw[g]};
        end

        if (UP == 0) begin : g_same
            assign w_phase = w_masked;
        end else if (UP > 0) begin : g_widen
            assign w_phase = {w_masked, {UP{1'b0}}};
        end else begin : g_round
            logic [AB:0] w_rnd;
            // round to nearest step; carry out wraps a full turn to zero
            assign w_rnd   = {1'b0, w_masked} + ((AB+1)'(1) << (SH - 1));
            assign w_phase = w_rnd[AB-1:SH];
        end

        // cosine is the sine one quadrant ahead
        assign w_sin[g] = classify(w_phase[PW-1 -: 2], w_phase[STB-1:0]);
        assign w_cos[g] = classify(w_phase[PW-1 -: 2] + 2'd1, w_phase[STB-1:0]);
    end

    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            o_req.data.sin_t[a] = w_sin[a];
            o_req.data.cos_t[a] = w_cos[a];
        end
    end

    assign o_req.valid   = i_angle.valid;
    assign i_angle.ready = o_req.ready;

endmodule

// ===== hw/rtl/erm_queue.sv =====
// ----------------------------------------------------------------------------
// erm_queue: short FIFO between the front and the back
// Decouples intake from the matrix pipeline so each side stalls on its own.
// ----------------------------------------------------------------------------
module erm_queue #(
    parameter int DEPTH = erm_pkg::QUEUE_DEPTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    erm_stream_if.sink   i_wr,
    erm_stream_if.source o_rd
);
    import erm_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_lookup_req      r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] n_count;
    logic             w_push;
    logic             w_pop;

    assign i_wr.ready = (r_count != CNT_W'(DEPTH));
    assign o_rd.valid = (r_count != '0);
    assign o_rd.data  = r_mem[r_rd_ptr];

    assign w_push = i_wr.valid && i_wr.ready;
    assign w_pop  = o_rd.valid && o_rd.ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_wr.data;
        end
    end

endmodule

// ===== hw/rtl/erm_back.sv =====
// ----------------------------------------------------------------------------
// erm_back: sine lookup and rotation matrix pipeline
// Table read, T = Ry*Rx, Rz*T products, then sums with clamping.
// ----------------------------------------------------------------------------
module erm_back #(
    parameter int SINE_TABLE_BITS = erm_pkg::SINE_TABLE_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    erm_stream_if.sink   i_req,
    erm_stream_if.source o_matrix
);
    import erm_pkg::*;

    localparam int STB = SINE_TABLE_BITS;
    localparam int Q   = 1 << STB;

    logic [SINE_VAL_W-1:0] w_lut [Q+1];

    for (genvar k = 0; k <= Q; k++) begin : g_lut
        localparam logic [SINE_VAL_W-1:0] ENTRY = sine_entry(k, STB);
        assign w_lut[k] = ENTRY;
    end

    // stage enables: a stage advances when it is empty or its successor moves
    logic w_en1, w_en2, w_en3, w_en4;
    logic r_s1_vld, r_s2_vld, r_s3_vld, r_out_vld;

    logic signed [COEF_W-1:0] n_s1_sin [AXES];
    logic signed [COEF_W-1:0] n_s1_cos [AXES];
    logic signed [COEF_W-1:0] r_s1_sin [AXES];
    logic signed [COEF_W-1:0] r_s1_cos [AXES];

    logic signed [COEF_W-1:0] n_s2_t [9];
    logic signed [COEF_W-1:0] r_s2_t [9];
    logic signed [COEF_W-1:0] r_s2_sz;
    logic signed [COEF_W-1:0] r_s2_cz;
    logic signed [COEF_W-1:0] w_neg_sz;

    logic signed [COEF_W-1:0] n_s3_a  [3];
    logic signed [COEF_W-1:0] n_s3_b  [3];
    logic signed [COEF_W-1:0] n_s3_c  [3];
    logic signed [COEF_W-1:0] n_s3_d  [3];
    logic signed [COEF_W-1:0] r_s3_a  [3];
    logic signed [COEF_W-1:0] r_s3_b  [3];
    logic signed [COEF_W-1:0] r_s3_c  [3];
    logic signed [COEF_W-1:0] r_s3_d  [3];
    logic signed [COEF_W-1:0] r_s3_t2 [3];

    logic signed [COEF_W:0]   w_sum0 [3];
    logic signed [COEF_W:0]   w_sum1 [3];
    t_matrix                  n_out;
    t_matrix                  r_out;

    assign w_en4       = !r_out_vld || o_matrix.ready;
    assign w_en3       = !r_s3_vld || w_en4;
    assign w_en2       = !r_s2_vld || w_en3;
    assign w_en1       = !r_s1_vld || w_en2;
    assign i_req.ready = w_en1;

    // stage 1: quarter-wave table reads
    always_comb begin
        logic [SINE_VAL_W-1:0] v_s;
        logic [SINE_VAL_W-1:0] v_c;
        for (int a = 0; a < AXES; a++) begin
            v_s = w_lut[i_req.data.sin_t[a].idx[STB:0]];
            v_c = w_lut[i_req.data.cos_t[a].idx[STB:0]];
            n_s1_sin[a] = i_req.data.sin_t[a].neg ? -$signed({1'b0, v_s})
                                                  :  $signed({1'b0, v_s});
            n_s1_cos[a] = i_req.data.cos_t[a].neg ? -$signed({1'b0, v_c})
                                                  :  $signed({1'b0, v_c});
        end
    end

    // stage 2: T = Ry*Rx; products with one or zero are exact
    always_comb begin
        n_s2_t[0] = r_s1_cos[1];
        n_s2_t[1] = mul_q14(r_s1_sin[1], r_s1_sin[0]);
        n_s2_t[2] = mul_q14(r_s1_sin[1], r_s1_cos[0]);
        n_s2_t[3] = '0;
        n_s2_t[4] = r_s1_cos[0];
        n_s2_t[5] = -r_s1_sin[0];
        n_s2_t[6] = -r_s1_sin[1];
        n_s2_t[7] = mul_q14(r_s1_cos[1], r_s1_sin[0]);
        n_s2_t[8] = mul_q14(r_s1_cos[1], r_s1_cos[0]);
    end

    // stage 3: row products of Rz*T; the bottom row of Rz passes T through
    assign w_neg_sz = -r_s2_sz;

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            n_s3_a[j] = mul_q14(r_s2_cz,  r_s2_t[j]);
            n_s3_b[j] = mul_q14(w_neg_sz, r_s2_t[3+j]);
            n_s3_c[j] = mul_q14(r_s2_sz,  r_s2_t[j]);
            n_s3_d[j] = mul_q14(r_s2_cz,  r_s2_t[3+j]);
        end
    end

    // stage 4: sums and clamp
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            w_sum0[j] = 17'(r_s3_a[j]) + 17'(r_s3_b[j]);
            w_sum1[j] = 17'(r_s3_c[j]) + 17'(r_s3_d[j]);
        end
        n_out.m00 = sat_q14(w_sum0[0]);
        n_out.m01 = sat_q14(w_sum0[1]);
        n_out.m02 = sat_q14(w_sum0[2]);
        n_out.m10 = sat_q14(w_sum1[0]);
        n_out.m11 = sat_q14(w_sum1[1]);
        n_out.m12 = sat_q14(w_sum1[2]);
        n_out.m20 = r_s3_t2[0];
        n_out.m21 = r_s3_t2[1];
        n_out.m22 = r_s3_t2[2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_s3_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (w_en1) begin
                r_s1_vld <= i_req.valid;
            end
            if (w_en2) begin
                r_s2_vld <= r_s1_vld;
            end
            if (w_en3) begin
                r_s3_vld <= r_s2_vld;
            end
            if (w_en4) begin
                r_out_vld <= r_s3_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_s1_sin <= n_s1_sin;
            r_s1_cos <= n_s1_cos;
        end
        if (w_en2) begin
            r_s2_t  <= n_s2_t;
            r_s2_sz <= r_s1_sin[2];
            r_s2_cz <= r_s1_cos[2];
        end
        if (w_en3) begin
            r_s3_a <= n_s3_a;
            r_s3_b <= n_s3_b;
            r_s3_c <= n_s3_c;
            r_s3_d <= n_s3_d;
            for (int j = 0; j < 3; j++) begin
                r_s3_t2[j] <= r_s2_t[6+j];
            end
        end
        if (w_en4) begin
            r_out <= n_out;
        end
    end

    assign o_matrix.valid = r_out_vld;
    assign o_matrix.data  = r_out;

    a_s3_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s3_vld && !w_en3 |=> r_s3_vld && $stable(r_s3_t2[0]) && $stable(r_s3_a[0]))
        else $error("stalled product stage lost its word");

    a_s2_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_vld && !w_en2 |=> r_s2_vld && $stable(r_s2_sz) && $stable(r_s2_cz))
        else $error("stalled T stage lost its word");

    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(r_s3_vld))
        else $error("output word appeared without a product stage word");

    a_trig_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_vld |->
            r_s1_sin[0] <= ONE_Q14 && r_s1_sin[0] >= -ONE_Q14 &&
            r_s1_cos[0] <= ONE_Q14 && r_s1_cos[0] >= -ONE_Q14 &&
            r_s1_sin[1] <= ONE_Q14 && r_s1_sin[1] >= -ONE_Q14 &&
            r_s1_cos[1] <= ONE_Q14 && r_s1_cos[1] >= -ONE_Q14 &&
            r_s1_sin[2] <= ONE_Q14 && r_s1_sin[2] >= -ONE_Q14 &&
            r_s1_cos[2] <= ONE_Q14 && r_s1_cos[2] >= -ONE_Q14)
        else $error("table read outside plus or minus one");

endmodule

// ===== hw/rtl/euler_rotation_matrix_core.sv =====
// ----------------------------------------------------------------------------
// euler_rotation_matrix_core: XYZ Euler angles to Q2.14 rotation matrix
// Angle word accepted to matrix word valid: queue write, then table, T, product and
// output registers. Throughput: one word per cycle while o_matrix is ready, set by the
// single-pass table read and product stages.
// Reset clears queue pointers and pipeline valid bits at once; no clearing pass.
// ----------------------------------------------------------------------------
module euler_rotation_matrix_core #(
    parameter int SINE_TABLE_BITS = erm_pkg::SINE_TABLE_BITS_DEF,
    parameter int ANGLE_BITS      = erm_pkg::ANGLE_BITS_DEF,
    parameter int QUEUE_DEPTH     = erm_pkg::QUEUE_DEPTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    erm_stream_if.sink   i_angle,
    erm_stream_if.source o_matrix
);
    import erm_pkg::*;

    erm_stream_if #(.T(t_lookup_req)) w_front_q ();
    erm_stream_if #(.T(t_lookup_req)) w_q_back ();

    erm_front #(
        .SINE_TABLE_BITS (SINE_TABLE_BITS),
        .ANGLE_BITS      (ANGLE_BITS)
    ) u_front (
        .i_angle (i_angle),
        .o_req   (w_front_q)
    );

    erm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_front_q),
        .o_rd    (w_q_back)
    );

    erm_back #(
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (w_q_back),
        .o_matrix (o_matrix)
    );

endmodule
